// ----- rtl/clirm_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clirm_pkg
// Types and constants shared by the CPU load meter core and its sequencer.
// ----------------------------------------------------------------------------
package clirm_pkg;

  localparam int unsigned CNT_W   = 32;
  localparam int unsigned BP_W    = 14;
  localparam int unsigned TPS_W   = 16;
  localparam int unsigned SUB_W   = CNT_W + 1;
  localparam int unsigned PROD_W  = CNT_W + BP_W;
  localparam int unsigned DIV_STEPS = BP_W;
  localparam int unsigned STEP_W  = $clog2(DIV_STEPS);

  localparam logic [BP_W-1:0]  BP_FULL   = BP_W'(10000);
  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1000);

  localparam logic CMD_IDLE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELAPSED,
    S_WINDOW,
    S_MUL,
    S_SAT,
    S_DIV,
    S_FINAL,
    S_DONE
  } seq_state_t;

  typedef struct packed {
    logic             valid;
    logic             command;
    logic [CNT_W-1:0] now_tick;
  } req_t;

  typedef struct packed {
    logic            valid;
    logic [BP_W-1:0] usage;
  } resp_t;

endpackage
`default_nettype wire

// ----- rtl/clirm_sub.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clirm_sub
// Shared subtractor: difference and borrow, used for tick deltas, window
// compares, the saturation check, divide steps and the final 10000 - share.
// ----------------------------------------------------------------------------
module clirm_sub
  import clirm_pkg::*;
(
  input  wire logic [SUB_W-1:0] a,
  input  wire logic [SUB_W-1:0] b,
  output logic      [SUB_W-1:0] diff,
  output logic                  borrow
);

  logic [SUB_W:0] full;

  assign full   = {1'b0, a} - {1'b0, b};
  assign diff   = full[SUB_W-1:0];
  assign borrow = full[SUB_W];

endmodule
`default_nettype wire

// ----- rtl/clirm_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// clirm_seq
// Meter state and sequencer. One subtractor is reused for the tick, window
// and saturation compares and for the restoring divide of idle_count * 10000 by the baseline.
// ----------------------------------------------------------------------------
module clirm_seq
  import clirm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire req_t             req,
  input  wire logic [TPS_W-1:0] tps,
  input  wire logic             res_ready,
  output logic                  busy,
  output resp_t                 resp
);

  seq_state_t state, state_next;

  logic [CNT_W-1:0]  idle_count;
  logic [CNT_W-1:0]  baseline;
  logic [CNT_W-1:0]  start_tick;
  logic [BP_W-1:0]   last_usage;
  logic              first_pending;

  logic [CNT_W-1:0]  now_q;
  logic [CNT_W-1:0]  elapsed;
  logic [CNT_W-1:0]  prod_hi;
  logic [BP_W-1:0]   prod_lo;
  logic [CNT_W-1:0]  rem;
  logic [BP_W-1:0]   quo;
  logic [STEP_W-1:0] step;
  logic [BP_W-1:0]   res;

  logic [SUB_W-1:0]  sub_a, sub_b, sub_diff;
  logic              sub_borrow;
  logic [PROD_W-1:0] mul;
  logic              base_zero;

  assign base_zero = (baseline == '0);
  assign mul       = PROD_W'(idle_count) * PROD_W'(BP_FULL);

  clirm_sub u_sub (
    .a      (sub_a),
    .b      (sub_b),
    .diff   (sub_diff),
    .borrow (sub_borrow)
  );

  // operand select for the shared subtractor
  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (state)
      S_ELAPSED: begin
        sub_a = {1'b0, now_q};
        sub_b = {1'b0, start_tick};
      end
      S_WINDOW: begin
        sub_a = {1'b0, elapsed};
        sub_b = SUB_W'(tps);
      end
      S_SAT: begin
        sub_a = {1'b0, prod_hi};
        sub_b = {1'b0, baseline};
      end
      S_DIV: begin
        sub_a = {rem, prod_lo[BP_W-1]};
        sub_b = {1'b0, baseline};
      end
      S_FINAL: begin
        sub_a = SUB_W'(BP_FULL);
        sub_b = SUB_W'(quo);
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid && req.command == CMD_QUERY) begin
          if (base_zero && first_pending) state_next = S_DONE;
          else state_next = S_ELAPSED;
        end
      end
      S_ELAPSED: state_next = S_WINDOW;
      S_WINDOW: begin
        if (!sub_borrow && !base_zero) state_next = S_MUL;
        else state_next = S_DONE;
      end
      S_MUL: state_next = S_SAT;
      S_SAT: begin
        if (!sub_borrow) state_next = S_DONE;
        else state_next = S_DIV;
      end
      S_DIV: begin
        if (step == '0) state_next = S_FINAL;
      end
      S_FINAL: state_next = S_DONE;
      S_DONE: begin
        if (res_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy       = (state != S_IDLE);
  assign resp.valid = (state == S_DONE);
  assign resp.usage = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_count    <= '0;
      baseline      <= '0;
      start_tick    <= '0;
      last_usage    <= '0;
      first_pending <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.command == CMD_IDLE) begin
              idle_count <= idle_count + CNT_W'(1);
            end else begin
              now_q <= req.now_tick;
              if (base_zero && first_pending) begin
                start_tick    <= req.now_tick;
                idle_count    <= '0;
                first_pending <= 1'b0;
                res           <= '0;
              end
            end
          end
        end
        S_ELAPSED: elapsed <= sub_diff[CNT_W-1:0];
        S_WINDOW: begin
          if (!sub_borrow && base_zero) begin
            // calibration window closed: take the baseline
            baseline   <= idle_count;
            idle_count <= '0;
            start_tick <= now_q;
            res        <= '0;
          end else if (sub_borrow) begin
            res <= base_zero ? '0 : last_usage;
          end
        end
        S_MUL: begin
          prod_hi    <= mul[PROD_W-1:BP_W];
          prod_lo    <= mul[BP_W-1:0];
          idle_count <= '0;
          start_tick <= now_q;
        end
        S_SAT: begin
          if (!sub_borrow) begin
            // quotient would exceed 14 bits: idle share clamps, load is 0
            last_usage <= '0;
            res        <= '0;
          end else begin
            rem  <= prod_hi;
            quo  <= '0;
            step <= STEP_W'(DIV_STEPS - 1);
          end
        end
        S_DIV: begin
          if (!sub_borrow) begin
            rem <= sub_diff[CNT_W-1:0];
            quo <= {quo[BP_W-2:0], 1'b1};
          end else begin
            rem <= sub_a[CNT_W-1:0];
            quo <= {quo[BP_W-2:0], 1'b0};
          end
          prod_lo <= {prod_lo[BP_W-2:0], 1'b0};
          step    <= step - STEP_W'(1);
        end
        S_FINAL: begin
          last_usage <= sub_borrow ? '0 : sub_diff[BP_W-1:0];
          res        <= sub_borrow ? '0 : sub_diff[BP_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/cpu_load_idle_ratio_meter_core.sv -----
`default_nettype none
// Idle events are taken back to back, one per cycle, while not busy. The first
// query goes straight to its result; others pass the elapsed and window
// states, then, if a window closes after calibration, multiply and saturate
// and, unless the idle share clamps, the 14-step restoring divide and a final
// step. One item at a time: the input stalls until the result enters the output
// register. Synchronous reset clears the meter, sets the window to 1000 ticks.
// ----------------------------------------------------------------------------
// cpu_load_idle_ratio_meter_core
// Idle-count CPU load meter: counts idle items, answers queries in basis
// points, with a window length register and a registered result output.
// ----------------------------------------------------------------------------
module cpu_load_idle_ratio_meter_core
  import clirm_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             command,
  input  wire logic [CNT_W-1:0] now_tick,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [BP_W-1:0]       usage_bp,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [TPS_W-1:0] ticks_per_second
);

  logic [TPS_W-1:0] tps;
  logic             busy;
  logic             out_free;
  req_t             req;
  resp_t            resp;

  assign in_stall  = busy;
  assign cfg_ready = !busy;
  assign out_free  = !out_valid || !out_stall;

  assign req.valid    = in_valid && !busy;
  assign req.command  = command;
  assign req.now_tick = now_tick;

  clirm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .tps       (tps),
    .res_ready (out_free),
    .busy      (busy),
    .resp      (resp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tps <= TPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      tps <= ticks_per_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= resp.valid;
      if (resp.valid) usage_bp <= resp.usage;
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/cpu_load_idle_ratio_meter_core_tb.sv -----
// ----------------------------------------------------------------------------
// cpu_load_idle_ratio_meter_core_tb
// Self-checking bench for the idle-count CPU load meter. A cycle-free
// predictor follows every accepted item. Each usage result is compared with
// the oldest prediction. Both sides idle at random. The window length is
// rewritten only once the core has gone quiet, between phases and every sixth window of the random phase.
// ----------------------------------------------------------------------------
module cpu_load_idle_ratio_meter_core_tb;
  import clirm_pkg::*;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             command = CMD_IDLE;
  logic [CNT_W-1:0] now_tick = '0;
  logic             out_stall = 1'b0;
  logic             cfg_valid = 1'b0;
  logic [TPS_W-1:0] ticks_per_second = TPS_RESET;
  logic             in_stall;
  logic             out_valid;
  logic             cfg_ready;
  logic [BP_W-1:0]  usage_bp;

  cpu_load_idle_ratio_meter_core u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .command          (command),
    .now_tick         (now_tick),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .usage_bp         (usage_bp),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .ticks_per_second (ticks_per_second)
  );

  // predictor state
  logic [CNT_W-1:0] idle_tally = '0;
  logic [CNT_W-1:0] idle_ref = '0;
  logic [CNT_W-1:0] window_origin = '0;
  logic [BP_W-1:0]  held_usage = '0;
  logic             awaiting_first_query = 1'b1;
  logic [TPS_W-1:0] window_len = TPS_RESET;

  logic [BP_W-1:0] usage_expected[$];

  int err_count = 0;
  int items_sent = 0;
  int idle_events = 0;
  int queries_sent = 0;
  int windows_closed = 0;
  int len_writes = 0;
  bit quiet = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [BP_W-1:0] predict_usage(input logic [CNT_W-1:0] tick);
    logic [CNT_W-1:0] span;
    logic [63:0]      share;
    span = tick - window_origin;
    if (idle_ref == '0) begin
      if (awaiting_first_query) begin
        window_origin = tick;
        idle_tally = '0;
        awaiting_first_query = 1'b0;
      end else if (span >= CNT_W'(window_len)) begin
        // calibration window over; a zero count keeps calibrating
        idle_ref = idle_tally;
        idle_tally = '0;
        window_origin = tick;
      end
      return '0;
    end
    if (span >= CNT_W'(window_len)) begin
      share = (64'(idle_tally) * 64'(BP_FULL)) / 64'(idle_ref);
      if (share > 64'(BP_FULL)) share = 64'(BP_FULL);
      held_usage = BP_FULL - BP_W'(share);
      idle_tally = '0;
      window_origin = tick;
      windows_closed++;
    end
    return held_usage;
  endfunction

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic send_item(input logic cmd, input logic [CNT_W-1:0] tick);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    now_tick <= tick;
    do @(posedge clk); while (in_stall);
    items_sent++;
    if (cmd == CMD_QUERY) begin
      usage_expected.push_back(predict_usage(tick));
      queries_sent++;
    end else begin
      idle_tally = idle_tally + CNT_W'(1);
      idle_events++;
    end
  endtask

  task automatic idle_burst(input int n);
    repeat (n) send_item(CMD_IDLE, $urandom());
  endtask

  task automatic query(input logic [CNT_W-1:0] tick);
    send_item(CMD_QUERY, tick);
  endtask

  // idle events give no result, so allow the core time to finish after the last one
  task automatic drain();
    in_valid <= 1'b0;
    while (usage_expected.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_window_len(input logic [TPS_W-1:0] len);
    drain();
    cfg_valid        <= 1'b1;
    ticks_per_second <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    window_len = len;
    len_writes++;
  endtask

  function automatic logic [TPS_W-1:0] pick_window_len();
    case ($urandom_range(0, 9))
      0: return TPS_W'(1);
      1: return '1;
      2: return '0;
      3: return TPS_W'($urandom_range(1, 65535));
      default: return TPS_W'($urandom_range(2, 100));
    endcase
  endfunction

  // result checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (usage_expected.size() == 0) begin
        flag_error($sformatf("result %0d with none expected", usage_bp));
      end else if (usage_bp !== usage_expected[0]) begin
        flag_error($sformatf("usage_bp expected %0d got %0d", usage_expected[0], usage_bp));
        void'(usage_expected.pop_front());
      end else begin
        void'(usage_expected.pop_front());
      end
    end
  end

  // output back-pressure
  initial begin
    int gap;
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  end

  task automatic test_zero_baseline();
    query(32'd10);
    query(32'd500);
    query(32'd1010);
  endtask

  task automatic test_calibration();
    idle_burst($urandom_range(9, 24));
    query(window_origin + CNT_W'(window_len) - 1);
    query(window_origin + CNT_W'(window_len));
  endtask

  task automatic test_window_extremes();
    write_window_len('1);
    idle_burst(2);
    query(window_origin + 32'd65534);
    query(window_origin + 32'd65535);
    write_window_len(TPS_W'(1));
    idle_burst(int'(idle_ref) + 3);
    query(window_origin + 1);
    query(window_origin + 1);
    idle_burst(int'(idle_ref) / 3);
    query(window_origin + 2);
  endtask

  task automatic test_zero_window();
    write_window_len('0);
    query(window_origin);
    idle_burst(1);
    query(window_origin);
  endtask

  task automatic test_tick_wrap();
    quiet = 1'b1;
    write_window_len(TPS_W'(16));
    query(32'hFFFF_FFF8);
    idle_burst(3);
    query(32'h0000_0007);
    query(32'h0000_0008);
    quiet = 1'b0;
  endtask

  task automatic test_random_windows();
    int goal;
    int windows;
    int n_idle;
    goal = items_sent + 500;
    windows = 0;
    while (items_sent < goal) begin
      if (windows % 6 == 0) write_window_len(pick_window_len());
      quiet = ($urandom_range(0, 9) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // noise: arbitrary commands and ticks
        repeat ($urandom_range(1, 6)) send_item(1'($urandom_range(0, 1)), $urandom());
      end else begin
        if ($urandom_range(0, 9) == 0)
          n_idle = $urandom_range(int'(idle_ref), 2 * int'(idle_ref) + 4);
        else
          n_idle = $urandom_range(0, int'(idle_ref) + int'(idle_ref) / 2);
        repeat (n_idle) begin
          send_item(CMD_IDLE, $urandom());
          if (window_len > 1 && $urandom_range(0, 7) == 0)
            query(window_origin + CNT_W'($urandom_range(0, int'(window_len) - 1)));
        end
        if ($urandom_range(0, 3) == 0)
          query(window_origin + CNT_W'(window_len));
        else
          query(window_origin + CNT_W'(window_len) + CNT_W'($urandom_range(0, 3)));
      end
      windows++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_zero_baseline();
    test_calibration();
    test_window_extremes();
    test_zero_window();
    test_tick_wrap();
    test_random_windows();
    drain();
    $display("Run covered %0d idle items and %0d queries, %0d usage windows closed,",
             idle_events, queries_sent, windows_closed);
    $display("over %0d window length settings; %0d mismatches seen", len_writes, err_count);
    if (err_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results still awaited", usage_expected.size());
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/clirm_pkg.sv
rtl/clirm_sub.sv
rtl/clirm_seq.sv
rtl/cpu_load_idle_ratio_meter_core.sv
tb/sv/cpu_load_idle_ratio_meter_core_tb.sv
